>>> rtl/ewh_pkg.sv
package ewh_pkg;

  localparam int NUM_BINS = 32;
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int IDX_W    = 5;
  localparam int DATA_W   = 32;
  localparam int WIDTH_W  = 31;
  localparam int REM_W    = DATA_W + BIN_W;
  localparam int NSTG     = BIN_W + 1;

  typedef enum logic [1:0] {
    REG_RANGE_MIN = 2'd0,
    REG_RANGE_MAX = 2'd1,
    REG_BIN_WIDTH = 2'd2
  } ewh_reg_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             last;
  } ewh_item_t;

endpackage

>>> rtl/equal_width_histogram.sv
// Channel   Handshake          Word
// input     push / full        sample, last_sample
// result    empty / pop        bin_index, bin_count, last_bin
// config    wr_en              wr_index, wr_data
//
// A sample runs through a six-stage front pipeline (difference, then one quotient bit
// per stage) and a two-entry queue; the back part counts it with a read and then a
// write of the single-port counter memory, and takes the next sample after that write.
// A marked sample is followed by a readout of 32 words, each read and then registered.
// Reset (rst, synchronous) clears all counters at once through per-bin valid bits.
// Either side may stall; a full queue holds the front pipeline and raises full.
module equal_width_histogram (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [ewh_pkg::DATA_W-1:0] sample,
  input  logic                              last_sample,
  output logic                              empty,
  input  logic                              pop,
  output logic [ewh_pkg::IDX_W-1:0]         bin_index,
  output logic [ewh_pkg::DATA_W-1:0]        bin_count,
  output logic                              last_bin,
  input  logic                              wr_en,
  input  logic [1:0]                        wr_index,
  input  logic [ewh_pkg::DATA_W-1:0]        wr_data
);
  import ewh_pkg::*;

  logic signed [DATA_W-1:0] range_min;
  logic signed [DATA_W-1:0] range_max;
  logic [WIDTH_W-1:0]       bin_width;

  logic      fq_push;
  logic      fq_full;
  ewh_item_t fq_item;
  logic      bq_pop;
  logic      bq_empty;
  ewh_item_t bq_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= '0;
      range_max <= '0;
      bin_width <= WIDTH_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RANGE_MIN: range_min <= wr_data;
        REG_RANGE_MAX: range_max <= wr_data;
        REG_BIN_WIDTH: bin_width <= wr_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  ewh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .sample      (sample),
    .last_sample (last_sample),
    .range_min   (range_min),
    .range_max   (range_max),
    .bin_width   (bin_width),
    .q_push      (fq_push),
    .q_item      (fq_item),
    .q_full      (fq_full)
  );

  ewh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (fq_push),
    .wr_item (fq_item),
    .full    (fq_full),
    .pop     (bq_pop),
    .rd_item (bq_item),
    .empty   (bq_empty)
  );

  ewh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (bq_empty),
    .q_item    (bq_item),
    .q_pop     (bq_pop),
    .empty     (empty),
    .pop       (pop),
    .bin_index (bin_index),
    .bin_count (bin_count),
    .last_bin  (last_bin)
  );

endmodule

>>> rtl/ewh_front.sv
module ewh_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic signed [ewh_pkg::DATA_W-1:0]  sample,
  input  logic                               last_sample,
  input  logic signed [ewh_pkg::DATA_W-1:0]  range_min,
  input  logic signed [ewh_pkg::DATA_W-1:0]  range_max,
  input  logic        [ewh_pkg::WIDTH_W-1:0] bin_width,
  output logic                               q_push,
  output ewh_pkg::ewh_item_t                 q_item,
  input  logic                               q_full
);
  import ewh_pkg::*;

  logic [NSTG-1:0]   vld;
  logic [DATA_W-1:0] rem  [NSTG];
  logic [BIN_W-1:0]  quo  [NSTG];
  logic [NSTG-1:0]   neg;
  logic [NSTG-1:0]   eq;
  logic [NSTG-1:0]   ovf;
  logic [NSTG-1:0]   lst;

  logic [DATA_W-1:0] rem_next [NSTG];
  logic [BIN_W-1:0]  quo_next [NSTG];
  logic [NSTG-1:0]   ovf_next;

  logic [DATA_W:0]    diff;
  logic [WIDTH_W-1:0] w_eff;
  logic [REM_W-1:0]   top_lim;
  logic               adv;

  assign w_eff   = (bin_width == '0) ? WIDTH_W'(1) : bin_width;
  assign diff    = {sample[DATA_W-1], sample} - {range_min[DATA_W-1], range_min};
  assign top_lim = REM_W'(w_eff) * REM_W'(NUM_BINS);

  // one restoring quotient bit per stage, most significant first
  always_comb begin
    rem_next[0] = diff[DATA_W-1:0];
    quo_next[0] = '0;
    ovf_next[0] = 1'b0;
    for (int j = 1; j < NSTG; j++) begin
      if (REM_W'(rem[j-1]) >= (REM_W'(w_eff) << (BIN_W - j))) begin
        rem_next[j] = DATA_W'(REM_W'(rem[j-1]) - (REM_W'(w_eff) << (BIN_W - j)));
        quo_next[j] = quo[j-1] | (BIN_W'(1) << (BIN_W - j));
      end else begin
        rem_next[j] = rem[j-1];
        quo_next[j] = quo[j-1];
      end
      ovf_next[j] = (j == 1) ? (REM_W'(rem[0]) >= top_lim) : ovf[j-1];
    end
  end

  assign adv    = !(vld[NSTG-1] && q_full);
  assign full   = !adv;
  assign q_push = vld[NSTG-1] && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg[0] <= diff[DATA_W];
      eq[0]  <= (sample == range_max);
      lst[0] <= last_sample;
      for (int j = 1; j < NSTG; j++) begin
        neg[j] <= neg[j-1];
        eq[j]  <= eq[j-1];
        lst[j] <= lst[j-1];
      end
      for (int j = 0; j < NSTG; j++) begin
        rem[j] <= rem_next[j];
        quo[j] <= quo_next[j];
        ovf[j] <= ovf_next[j];
      end
    end
  end

  always_comb begin
    q_item.last = lst[NSTG-1];
    priority if (neg[NSTG-1]) begin
      q_item.bin = '0;
    end else if (ovf[NSTG-1]) begin
      q_item.bin = BIN_W'(NUM_BINS - 1);
    end else if (quo[NSTG-1] == '0) begin
      q_item.bin = '0;
    end else if (eq[NSTG-1]) begin
      q_item.bin = BIN_W'(NUM_BINS - 1);
    end else begin
      q_item.bin = quo[NSTG-1];
    end
  end

endmodule

>>> rtl/ewh_queue.sv
module ewh_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ewh_pkg::ewh_item_t wr_item,
  output logic               full,
  input  logic               pop,
  output ewh_pkg::ewh_item_t rd_item,
  output logic               empty
);
  import ewh_pkg::*;

  ewh_item_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= wr_item;
    end
  end

endmodule

>>> rtl/ewh_back.sv
module ewh_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  ewh_pkg::ewh_item_t               q_item,
  output logic                             q_pop,
  output logic                             empty,
  input  logic                             pop,
  output logic [ewh_pkg::IDX_W-1:0]        bin_index,
  output logic [ewh_pkg::DATA_W-1:0]       bin_count,
  output logic                             last_bin
);
  import ewh_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_INC,
    B_DRD,
    B_DWR
  } state_t;

  state_t            state;
  logic [DATA_W-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0] valid;
  logic [DATA_W-1:0] rdata;
  logic              rvld;
  logic [BIN_W-1:0]  cur_bin;
  logic              cur_last;
  logic [BIN_W-1:0]  idx;
  logic              out_valid;

  logic              re;
  logic [BIN_W-1:0]  raddr;
  logic              we;
  logic [DATA_W-1:0] cnt_old;
  logic [DATA_W-1:0] wdata;
  logic              last_idx;
  logic              load_out;

  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign re       = q_pop || (state == B_DRD);
  assign raddr    = (state == B_IDLE) ? q_item.bin : idx;
  assign we       = (state == B_INC);
  assign cnt_old  = rvld ? rdata : '0;
  assign wdata    = (cnt_old == '1) ? cnt_old : cnt_old + DATA_W'(1);
  assign last_idx = (idx == BIN_W'(NUM_BINS - 1));
  assign empty    = !out_valid;
  assign load_out = (state == B_DWR) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[cur_bin] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      valid     <= '0;
      rvld      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (re) begin
        rvld <= valid[raddr];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cur_bin  <= q_item.bin;
            cur_last <= q_item.last;
            state    <= B_INC;
          end
        end
        B_INC: begin
          valid[cur_bin] <= 1'b1;
          if (cur_last) begin
            idx   <= '0;
            state <= B_DRD;
          end else begin
            state <= B_IDLE;
          end
        end
        B_DRD: begin
          state <= B_DWR;
        end
        B_DWR: begin
          // hold the read word until the output register frees up
          if (load_out) begin
            bin_index  <= IDX_W'(idx);
            bin_count  <= cnt_old;
            last_bin   <= last_idx;
            valid[idx] <= 1'b0;
            if (last_idx) begin
              state <= B_IDLE;
            end else begin
              idx   <= idx + BIN_W'(1);
              state <= B_DRD;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> verif/tb_equal_width_histogram.sv
`timescale 1ns / 100ps

module tb_equal_width_histogram;
  import ewh_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int NO_TYPED = -1;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_sel;
    logic [31:0] value;
    logic        last;
    int          typed_bin;
  } stim_row_t;

  typedef struct {
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] count;
    logic              last;
  } bin_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [DATA_W-1:0] sample = '0;
  logic last_sample = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [IDX_W-1:0] bin_index;
  logic [DATA_W-1:0] bin_count;
  logic last_bin;
  logic wr_en = 1'b0;
  logic [1:0] wr_index = REG_RANGE_MIN;
  logic [DATA_W-1:0] wr_data = '0;

  equal_width_histogram dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .sample(sample), .last_sample(last_sample),
    .empty(empty), .pop(pop),
    .bin_index(bin_index), .bin_count(bin_count), .last_bin(last_bin),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // settings as the block should hold them
  logic signed [31:0] cfg_min = '0;
  logic signed [31:0] cfg_max = '0;
  logic [30:0] cfg_width = 31'd1;
  logic [DATA_W-1:0] tally [NUM_BINS];
  bin_report_t reports_due [$];

  int sender_idle = 0;
  int receiver_stall = 0;
  int bad_words = 0;

  initial begin
    for (int i = 0; i < NUM_BINS; i++) tally[i] = '0;
  end

  stim_row_t directed_rows [31] = '{
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h0000_0000, 1'b1, 0},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'hFFFF_FFFF, 1'b1, 0},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h0000_0005, 1'b1, 5},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h0000_0020, 1'b1, 31},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h7FFF_FFFF, 1'b1, 31},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h8000_0000, 1'b1, 0},
    // zero width counts as one
    '{ROW_WRITE,  REG_BIN_WIDTH, 32'h0000_0000, 1'b0, NO_TYPED},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h0000_0007, 1'b1, 7},
    '{ROW_WRITE,  REG_SPARE,     32'h1234_5678, 1'b0, NO_TYPED},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h0000_0009, 1'b1, 9},
    '{ROW_WRITE,  REG_RANGE_MIN, 32'h8000_0000, 1'b0, NO_TYPED},
    '{ROW_WRITE,  REG_RANGE_MAX, 32'h7FFF_FFFF, 1'b0, NO_TYPED},
    '{ROW_WRITE,  REG_BIN_WIDTH, 32'h7FFF_FFFF, 1'b0, NO_TYPED},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h7FFF_FFFF, 1'b1, 31},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h8000_0000, 1'b1, 0},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h7FFF_FFFE, 1'b1, 2},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'hFFFF_FFFF, 1'b1, 1},
    // top bit of the width word is dropped
    '{ROW_WRITE,  REG_BIN_WIDTH, 32'h8000_0001, 1'b0, NO_TYPED},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h8000_0014, 1'b1, 20},
    '{ROW_WRITE,  REG_RANGE_MAX, 32'h8000_0003, 1'b0, NO_TYPED},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h8000_0003, 1'b1, 31},
    // equal to max but still in the first bin
    '{ROW_WRITE,  REG_RANGE_MAX, 32'h8000_0000, 1'b0, NO_TYPED},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h8000_0000, 1'b1, 0},
    // max below min
    '{ROW_WRITE,  REG_RANGE_MIN, 32'h0000_0064, 1'b0, NO_TYPED},
    '{ROW_WRITE,  REG_RANGE_MAX, 32'hFFFF_FF9C, 1'b0, NO_TYPED},
    '{ROW_WRITE,  REG_BIN_WIDTH, 32'h0000_000A, 1'b0, NO_TYPED},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h0000_0096, 1'b1, 5},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'hFFFF_FF9C, 1'b1, 0},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h0000_0082, 1'b0, NO_TYPED},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h0000_0082, 1'b0, NO_TYPED},
    '{ROW_SAMPLE, REG_RANGE_MIN, 32'h0000_07D0, 1'b1, NO_TYPED}
  };

  function automatic logic [BIN_W-1:0] select_bin(logic [31:0] s);
    longint d;
    longint unsigned du, w, q;
    d = longint'($signed(s)) - longint'(cfg_min);
    w = (cfg_width == 0) ? 1 : cfg_width;
    if (d < 0) return '0;
    du = d;
    q = du / w;
    if (q == 0) return '0;
    if (s == cfg_max || q >= NUM_BINS) return BIN_W'(NUM_BINS - 1);
    return BIN_W'(q);
  endfunction

  // count one sample; on the marked one queue the whole readout and clear
  task automatic count_sample(logic [31:0] s, logic last, int typed_bin);
    logic [BIN_W-1:0] b;
    bin_report_t r;
    b = select_bin(s);
    if (tally[b] != '1) tally[b] = tally[b] + 1;
    if (last) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        r.index = IDX_W'(i);
        if (typed_bin == NO_TYPED) r.count = tally[i];
        else r.count = (i == typed_bin) ? 1 : 0;
        r.last = (i == NUM_BINS - 1);
        reports_due.push_back(r);
        tally[i] = '0;
      end
    end
  endtask

  task automatic send_word(logic [31:0] s, logic last, int typed_bin);
    if (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    push <= 1'b1;
    sample <= s;
    last_sample <= last;
    do @(posedge clk); while (full);
    count_sample(s, last, typed_bin);
  endtask

  // hold the sender until the readout is drained and the pipeline is empty
  task automatic settle();
    push <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_RANGE_MIN: cfg_min = value;
      REG_RANGE_MAX: cfg_max = value;
      REG_BIN_WIDTH: cfg_width = value[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic new_setting();
    logic [31:0] lo, hi, w;
    int sel;
    case ($urandom_range(3))
      0: begin
        lo = $urandom;
        hi = $urandom;
        w = $urandom;
      end
      1: begin
        lo = (int'($urandom_range(2000)) - 1000) <<< 16;
        w = $urandom_range(32'h3FFFF, 1);
        hi = lo + w * NUM_BINS;
      end
      2: begin
        sel = $urandom_range(2);
        lo = $urandom;
        w = (sel == 0) ? 32'd0 : (sel == 1) ? 32'd1 : 32'h7FFF_FFFF;
        hi = lo + w * NUM_BINS - $urandom_range(1);
      end
      default: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
        w = 32'h07FF_FFFF;
      end
    endcase
    write_reg(REG_RANGE_MIN, lo);
    write_reg(REG_RANGE_MAX, hi);
    write_reg(REG_BIN_WIDTH, w);
  endtask

  // aim half of the samples at bins of the current setting, with edges and noise mixed in
  function automatic logic [31:0] pick_sample();
    logic signed [63:0] w, at;
    w = (cfg_width == 0) ? 64'sd1 : {33'd0, cfg_width};
    case ($urandom_range(9))
      0: return $urandom;
      1: return cfg_max;
      2: return cfg_min;
      3: return cfg_min - 1;
      4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: begin
        at = 64'(cfg_min) + 64'($urandom_range(NUM_BINS + 1)) * w
           + 64'($urandom_range(32'(w - 1)));
        return at[31:0];
      end
    endcase
  endfunction

  task automatic run_phase(int n_items, int s_idle, int r_stall);
    int sent, len;
    sender_idle = s_idle;
    receiver_stall = r_stall;
    sent = 0;
    while (sent < n_items) begin
      if (sent == 0 || $urandom_range(3) == 0) begin
        settle();
        new_setting();
      end
      len = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : $urandom_range(4, 1);
      for (int k = 0; k < len; k++) begin
        send_word(pick_sample(), k == len - 1, NO_TYPED);
        sent++;
      end
    end
  endtask

  task automatic note_bad(string msg);
    bad_words++;
    if (bad_words <= 10) $display("%s", msg);
  endtask

  task automatic check_word();
    bin_report_t want;
    if (reports_due.size() == 0) begin
      note_bad($sformatf("unexpected word: bin %0d count %0d last %0b",
                         bin_index, bin_count, last_bin));
    end else begin
      want = reports_due.pop_front();
      if (bin_index !== want.index || bin_count !== want.count || last_bin !== want.last)
        note_bad($sformatf("mismatch: expected bin %0d count %0d last %0b, got %0d %0d %0b",
                           want.index, want.count, want.last,
                           bin_index, bin_count, last_bin));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) check_word();
    pop <= ($urandom_range(99) >= receiver_stall);
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        send_word(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed_bin);
      end
    end
    run_phase(72, 0, 0);
    run_phase(72, 80, 0);
    run_phase(72, 0, 80);
    run_phase(70, 17, 17);
    settle();
    if (bad_words == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
